/* design/dbd_pkg.sv */
`default_nettype none

package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 23;
    localparam int DIFF_W  = 22;
    localparam int QY_W    = 8;
    localparam int MPART_W = 9;

    // days in the whole months before month m of a common year
    localparam logic [MPART_W-1:0] MONTH_START [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd396, 9'd427
    };

    // March: first month that sees the leap day
    localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_PW    = 27;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

`default_nettype wire

/* design/dbd_ordinal.sv */
`default_nettype none

module dbd_ordinal #(
    parameter int YEAR_LIMIT = 9999
) (
    input  wire                              i_clk,
    input  dbd_pkg::t_stage_en               i_en,
    input  wire  [dbd_pkg::YEAR_W-1:0]       i_year,
    input  wire  [dbd_pkg::MONTH_W-1:0]      i_month,
    input  wire  [dbd_pkg::DAY_W-1:0]        i_day,
    output logic [dbd_pkg::ORD_W-1:0]        o_ordinal
);
    import dbd_pkg::*;

    localparam logic [15:0] LIMIT = 16'(YEAR_LIMIT);

    // stage 1: saturate the year, divide it by 100
    logic [YEAR_W-1:0]      y_sat;
    logic [DIV100_PW-1:0]   prod;
    logic [YEAR_W-1:0]      r_year;
    logic [QY_W-1:0]        r_qy;
    logic [MONTH_W-1:0]     r_month;
    logic [DAY_W-1:0]       r_day;

    always_comb begin
        if ({2'b00, i_year} > LIMIT) begin
            y_sat = LIMIT[YEAR_W-1:0];
        end else begin
            y_sat = i_year;
        end
        prod = DIV100_PW'(y_sat) * DIV100_PW'(DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_year  <= y_sat;
            r_qy    <= prod[DIV100_SHIFT +: QY_W];
            r_month <= i_month;
            r_day   <= i_day;
        end
    end

    // stage 2: leap flag, whole-year count and day-of-year
    logic                   ry_zero;
    logic                   y_zero;
    logic                   leap;
    logic [YEAR_W-1:0]      n_n;
    logic [QY_W-1:0]        n_q100n;
    logic [MPART_W-1:0]     n_mpart;
    logic [YEAR_W-1:0]      r_n;
    logic [QY_W-1:0]        r_q100n;
    logic [MPART_W-1:0]     r_mpart;

    always_comb begin
        ry_zero = (r_year == (YEAR_W'(r_qy) * YEAR_W'(100)));
        y_zero  = (r_year == '0);
        leap    = (r_year[1:0] == 2'b00) && (!ry_zero || (r_qy[1:0] == 2'b00));
        if (y_zero) begin
            n_n     = '0;
            n_q100n = '0;
        end else begin
            n_n     = r_year - YEAR_W'(1);
            n_q100n = r_qy - QY_W'(ry_zero);
        end
        n_mpart = MONTH_START[r_month]
                + MPART_W'((r_month >= MONTH_MARCH) && leap)
                + MPART_W'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_n     <= n_n;
            r_q100n <= n_q100n;
            r_mpart <= n_mpart;
        end
    end

    // stage 3: closed form of the whole years plus the day-of-year
    logic [ORD_W-1:0] n_ord;
    logic [ORD_W-1:0] r_ord;

    always_comb begin
        n_ord = ORD_W'(r_n) * ORD_W'(365)
              + ORD_W'(r_n >> 2)
              - ORD_W'(r_q100n)
              + ORD_W'(r_q100n >> 2)
              + ORD_W'(r_mpart);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_ord <= n_ord;
        end
    end

    assign o_ordinal = r_ord;

endmodule

`default_nettype wire

/* design/days_between_dates.sv */
// Days between two proleptic Gregorian dates.
// Slave channel (s_axis_*): one request per date pair, packed in s_axis_tdata
// as first year, month, day, then second year, month, day from bit 0 up.
// Master channel (m_axis_*): one result per request, day difference in the
// low 22 bits of m_axis_tdata and the "second date is later" flag above it.
// Years above YEAR_LIMIT are clamped to YEAR_LIMIT; day and month values are
// not checked and simply add their share to each date's day count.
// Each request passes through three stages per date (divide by 100, leap
// and month sums, year closed form) and one compare stage. Throughput: one
// request per cycle while the output is not stalled.
// Each stage carries a valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up under a stall and a stalled result
// holds in the output register while earlier stages keep filling.
// s_axis_tready only drops once all four stages hold a request.
// Reset (i_rst_n low, synchronous) empties the pipeline; data is not cleared.
`default_nettype none

module days_between_dates #(
    parameter int YEAR_LIMIT = 9999
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // first_year[13:0], first_month[17:14], first_day[22:18],
    // second_year[36:23], second_month[40:37], second_day[45:41], zero pad
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // day_difference[21:0], second_is_later[22], zero pad
    output logic [23:0] m_axis_tdata
);
    import dbd_pkg::*;

    // valid bit per stage: [0..2] ordinal stages, [3] output register
    logic [3:0] r_valid;
    logic [3:0] stage_rdy;
    logic [3:0] n_valid;
    t_stage_en  stage_en;

    // a stage loads when empty or when its successor takes its request
    always_comb begin
        stage_rdy[3] = !r_valid[3] || m_axis_tready;
        stage_rdy[2] = !r_valid[2] || stage_rdy[3];
        stage_rdy[1] = !r_valid[1] || stage_rdy[2];
        stage_rdy[0] = !r_valid[0] || stage_rdy[1];
        n_valid[0] = stage_rdy[0] ? s_axis_tvalid : r_valid[0];
        n_valid[1] = stage_rdy[1] ? r_valid[0]    : r_valid[1];
        n_valid[2] = stage_rdy[2] ? r_valid[1]    : r_valid[2];
        n_valid[3] = stage_rdy[3] ? r_valid[2]    : r_valid[3];
        stage_en.s1 = stage_rdy[0];
        stage_en.s2 = stage_rdy[1];
        stage_en.s3 = stage_rdy[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign s_axis_tready = stage_rdy[0];

    // day ordinal of each date
    logic [ORD_W-1:0] ord_a;
    logic [ORD_W-1:0] ord_b;

    dbd_ordinal #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_ord_first (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_year    (s_axis_tdata[13:0]),
        .i_month   (s_axis_tdata[17:14]),
        .i_day     (s_axis_tdata[22:18]),
        .o_ordinal (ord_a)
    );

    dbd_ordinal #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_ord_second (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_year    (s_axis_tdata[36:23]),
        .i_month   (s_axis_tdata[40:37]),
        .i_day     (s_axis_tdata[45:41]),
        .o_ordinal (ord_b)
    );

    // output stage: compare and take the absolute difference
    logic              n_later;
    logic [ORD_W-1:0]  n_diff;
    logic              r_later;
    logic [DIFF_W-1:0] r_diff;

    always_comb begin
        n_later = (ord_b > ord_a);
        if (n_later) begin
            n_diff = ord_b - ord_a;
        end else begin
            n_diff = ord_a - ord_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[3]) begin
            r_later <= n_later;
            r_diff  <= n_diff[DIFF_W-1:0];
        end
    end

    assign m_axis_tvalid = r_valid[3];
    assign m_axis_tdata  = {1'b0, r_later, r_diff};

`ifndef SYNTHESIS
    // back-pressure reaches the input only once every stage is occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_valid == 4'b1111))
        else $error("input blocked with an empty stage");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_valid[0])
        else $error("accepted request not held in first stage");

    // a full third ordinal stage whose successor is blocked keeps its request
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[2] && !stage_rdy[3]) |=> r_valid[2])
        else $error("stage 3 request dropped under stall");

    // the later flag never comes with a zero difference
    a_later_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_later) |-> (r_diff != '0))
        else $error("later flag set on equal dates");
`endif

endmodule

`default_nettype wire
